/* rtl/core/lrast_pkg.sv */
// Shared types and constants of the line rasterizer.
// No dependencies; imported by the interfaces and every module of the block.
package lrast_pkg;

  // field widths
  localparam int X_W     = 8;
  localparam int Y_W     = 7;
  localparam int CW      = 8;        // common coordinate width after axis swap
  localparam int EW      = CW + 3;   // signed doubled error term
  localparam int LIM_W   = 11;       // wide enough for any frame limit
  localparam int ADDR_W  = 15;
  localparam int COUNT_W = 3;
  localparam int COLOR_W = 16;
  localparam int ADDR_SLOTS = 4;

  // defaults of the top-level parameters
  localparam int FRAME_WIDTH_DEF       = 160;
  localparam int FRAME_HEIGHT_DEF      = 120;
  localparam int PIXELS_PER_RESULT_DEF = 4;

  // register file
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_PIXEL_COLOR = 1'b0;  // word index of pixel_color
  localparam logic [COLOR_W-1:0] COLOR_RESET = 16'hF800;

  typedef struct packed {
    logic load;    // take a new pair of endpoints
    logic orient;  // pick major axis and walk direction
    logic init;    // spans, error term, start address
    logic emit;    // produce one group of pixels
  } lrast_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
    logic last_grp;  // current group ends the line
  } lrast_sts_t;

endpackage

/* rtl/core/lrast_cmd_if.sv */
// Endpoint channel of the line rasterizer: valid/ready plus one line's endpoints.
// Depends on lrast_pkg.
interface lrast_cmd_if import lrast_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [X_W-1:0] start_x;
  logic [Y_W-1:0] start_y;
  logic [X_W-1:0] end_x;
  logic [Y_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

/* rtl/core/lrast_grp_if.sv */
// Pixel group channel of the line rasterizer: valid/ready plus one group of addresses.
// Depends on lrast_pkg.
interface lrast_grp_if import lrast_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_addr_0;
  logic [ADDR_W-1:0]  pixel_addr_1;
  logic [ADDR_W-1:0]  pixel_addr_2;
  logic [ADDR_W-1:0]  pixel_addr_3;
  logic [COUNT_W-1:0] pixel_count;
  logic [COLOR_W-1:0] write_color;
  logic               last;

  modport source (output valid, pixel_addr_0, pixel_addr_1, pixel_addr_2, pixel_addr_3,
                  pixel_count, write_color, last, input ready);
  modport sink   (input valid, pixel_addr_0, pixel_addr_1, pixel_addr_2, pixel_addr_3,
                  pixel_count, write_color, last, output ready);
endinterface

/* rtl/core/line_rasterizer.sv */
// Channel   | Dir | Handshake          | Word
// cmd_i     | in  | valid/ready        | start_x, start_y, end_x, end_y
// grp_o     | out | valid/ready        | pixel_addr_0..3, pixel_count, write_color, last
// APB       | in  | psel/penable/pwrite| pixel_color at byte address 0
//
// An accepted line passes through load, orient and init, after which the walk unit
// emits one group per cycle while the output register is free.
// Stalls on grp_o hold the walk; a new word is taken once the last group is registered.
// Reset clears the controller and output valid; pixel_color returns to 16'hF800.
// Top level of the line rasterizer; depends on lrast_pkg, lrast_cmd_if, lrast_grp_if,
// lrast_ctrl and lrast_dp.
module line_rasterizer import lrast_pkg::*; #(
  parameter int FRAME_WIDTH       = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT      = FRAME_HEIGHT_DEF,
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrast_cmd_if.sink          cmd_i,
  lrast_grp_if.source        grp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COLOR_W-1:0] color_q;
  logic               sel_color;
  lrast_cmd_t         cmd;
  lrast_sts_t         sts;
  logic               in_ready;

  assign sel_color = (paddr[PADDR_W-1:2] == REG_PIXEL_COLOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (psel && penable && pwrite && sel_color) begin
      color_q <= pwdata[COLOR_W-1:0];
    end
  end

  assign prdata = sel_color ? PDATA_W'(color_q) : '0;
  assign pready = 1'b1;

  lrast_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign cmd_i.ready = in_ready;

  lrast_dp #(
    .FRAME_WIDTH       (FRAME_WIDTH),
    .FRAME_HEIGHT      (FRAME_HEIGHT),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_x_i      (cmd_i.start_x),
    .start_y_i      (cmd_i.start_y),
    .end_x_i        (cmd_i.end_x),
    .end_y_i        (cmd_i.end_y),
    .color_i        (color_q),
    .grp_ready_i    (grp_o.ready),
    .grp_valid_o    (grp_o.valid),
    .pixel_addr_0_o (grp_o.pixel_addr_0),
    .pixel_addr_1_o (grp_o.pixel_addr_1),
    .pixel_addr_2_o (grp_o.pixel_addr_2),
    .pixel_addr_3_o (grp_o.pixel_addr_3),
    .pixel_count_o  (grp_o.pixel_count),
    .write_color_o  (grp_o.write_color),
    .last_o         (grp_o.last)
  );

endmodule

/* rtl/core/lrast_dp.sv */
// Datapath of the line rasterizer: endpoint registers, Bresenham walk of up to
// four pixels a cycle while the output is free, and the output word register. Depends on lrast_pkg.
module lrast_dp import lrast_pkg::*; #(
  parameter int FRAME_WIDTH       = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT      = FRAME_HEIGHT_DEF,
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrast_cmd_t         cmd_i,
  output lrast_sts_t         sts_o,
  input  logic [X_W-1:0]     start_x_i,
  input  logic [Y_W-1:0]     start_y_i,
  input  logic [X_W-1:0]     end_x_i,
  input  logic [Y_W-1:0]     end_y_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic               grp_ready_i,
  output logic               grp_valid_o,
  output logic [ADDR_W-1:0]  pixel_addr_0_o,
  output logic [ADDR_W-1:0]  pixel_addr_1_o,
  output logic [ADDR_W-1:0]  pixel_addr_2_o,
  output logic [ADDR_W-1:0]  pixel_addr_3_o,
  output logic [COUNT_W-1:0] pixel_count_o,
  output logic [COLOR_W-1:0] write_color_o,
  output logic               last_o
);

  localparam int GROUP = (PIXELS_PER_RESULT < 1) ? 1 :
                         ((PIXELS_PER_RESULT > ADDR_SLOTS) ? ADDR_SLOTS : PIXELS_PER_RESULT);
  localparam logic [LIM_W-1:0]  X_LIM      = LIM_W'(FRAME_WIDTH - 1);
  localparam logic [LIM_W-1:0]  Y_LIM      = LIM_W'(FRAME_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(FRAME_WIDTH);

  function automatic logic [CW-1:0] clamp(logic [LIM_W-1:0] v, logic [LIM_W-1:0] lim);
    return (v > lim) ? lim[CW-1:0] : v[CW-1:0];
  endfunction

  // endpoints, clamped to the frame
  logic [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  // walk state
  logic                     steep_q;
  logic [CW-1:0]            a_q, b_q, a2_q, b2_q;
  logic signed [EW-1:0]     err_q, da2_q, db2_q;
  logic [ADDR_W-1:0]        addr_q, major_q, minor_q;
  // output word
  logic                     grp_valid_q;
  logic [ADDR_W-1:0]        slot_q [ADDR_SLOTS];
  logic [COUNT_W-1:0]       count_q;
  logic [COLOR_W-1:0]       color_q;
  logic                     last_q;

  // orientation
  logic [CW-1:0] adx, ady, pa1, pb1, pa2, pb2;
  logic          steep_c;
  always_comb begin
    adx     = (x2_q > x1_q) ? x2_q - x1_q : x1_q - x2_q;
    ady     = (y2_q > y1_q) ? y2_q - y1_q : y1_q - y2_q;
    steep_c = ady > adx;
    pa1     = steep_c ? y1_q : x1_q;
    pb1     = steep_c ? x1_q : y1_q;
    pa2     = steep_c ? y2_q : x2_q;
    pb2     = steep_c ? x2_q : y2_q;
  end

  // spans and start address
  logic [CW-1:0]     da, db, row0, col0;
  logic              step_up;
  logic [ADDR_W-1:0] addr0, major0, minor0;
  always_comb begin
    da      = a2_q - a_q;
    db      = (b2_q > b_q) ? b2_q - b_q : b_q - b2_q;
    step_up = b2_q > b_q;
    row0    = steep_q ? a_q : b_q;
    col0    = steep_q ? b_q : a_q;
    addr0   = ADDR_W'(row0) * ROW_STRIDE + ADDR_W'(col0);
    major0  = steep_q ? ROW_STRIDE : ADDR_W'(1);
    if (steep_q) begin
      minor0 = step_up ? ADDR_W'(1) : ~ADDR_W'(0);
    end else begin
      minor0 = step_up ? ROW_STRIDE : ADDR_W'(0) - ROW_STRIDE;
    end
  end

  // one group: chain of Bresenham steps on the error term and address
  logic signed [EW-1:0] err_c [ADDR_SLOTS+1];
  logic [ADDR_W-1:0]    addr_c [ADDR_SLOTS+1];
  logic signed [EW-1:0] err_t;
  logic [CW-1:0]        rem;
  logic                 last_c;
  logic [COUNT_W-1:0]   count_c;
  logic [ADDR_W-1:0]    slot_c [ADDR_SLOTS];
  always_comb begin
    err_c[0]  = err_q;
    addr_c[0] = addr_q;
    err_t     = '0;
    for (int k = 0; k < ADDR_SLOTS; k++) begin
      err_t = err_c[k] - db2_q;
      if (err_t[EW-1]) begin
        err_c[k+1]  = err_t + da2_q;
        addr_c[k+1] = addr_c[k] + major_q + minor_q;
      end else begin
        err_c[k+1]  = err_t;
        addr_c[k+1] = addr_c[k] + major_q;
      end
    end
    rem     = a2_q - a_q;
    last_c  = rem < CW'(GROUP);
    count_c = last_c ? COUNT_W'(rem) + COUNT_W'(1) : COUNT_W'(GROUP);
    for (int s = 0; s < ADDR_SLOTS; s++) begin
      slot_c[s] = (COUNT_W'(s) < count_c) ? addr_c[s] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q <= clamp(LIM_W'(start_x_i), X_LIM);
      y1_q <= clamp(LIM_W'(start_y_i), Y_LIM);
      x2_q <= clamp(LIM_W'(end_x_i), X_LIM);
      y2_q <= clamp(LIM_W'(end_y_i), Y_LIM);
    end
    if (cmd_i.orient) begin
      steep_q <= steep_c;
      // walk from the smaller major coordinate; ties keep the first endpoint
      if (pa1 > pa2) begin
        a_q <= pa2; b_q <= pb2; a2_q <= pa1; b2_q <= pb1;
      end else begin
        a_q <= pa1; b_q <= pb1; a2_q <= pa2; b2_q <= pb2;
      end
    end
    if (cmd_i.init) begin
      err_q   <= $signed(EW'(da));
      da2_q   <= $signed({2'b00, da, 1'b0});
      db2_q   <= $signed({2'b00, db, 1'b0});
      addr_q  <= addr0;
      major_q <= major0;
      minor_q <= minor0;
    end
    if (cmd_i.emit) begin
      a_q     <= a_q + CW'(GROUP);
      err_q   <= err_c[GROUP];
      addr_q  <= addr_c[GROUP];
      slot_q  <= slot_c;
      count_q <= count_c;
      color_q <= color_i;
      last_q  <= last_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      grp_valid_q <= 1'b1;
    end else if (grp_ready_i) begin
      grp_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !grp_valid_q || grp_ready_i;
  assign sts_o.last_grp = last_c;

  assign grp_valid_o    = grp_valid_q;
  assign pixel_addr_0_o = slot_q[0];
  assign pixel_addr_1_o = slot_q[1];
  assign pixel_addr_2_o = slot_q[2];
  assign pixel_addr_3_o = slot_q[3];
  assign pixel_count_o  = count_q;
  assign write_color_o  = color_q;
  assign last_o         = last_q;

endmodule

/* rtl/core/lrast_ctrl.sv */
// Controller of the line rasterizer: sequences load, orient, init and the walk.
// Depends on lrast_pkg.
module lrast_ctrl import lrast_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lrast_sts_t sts_i,
  output lrast_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ORIENT = 2'd1;
  localparam logic [1:0] ST_INIT   = 2'd2;
  localparam logic [1:0] ST_WALK   = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.orient = (state_q == ST_ORIENT);
  assign cmd_o.init   = (state_q == ST_INIT);
  assign cmd_o.emit   = (state_q == ST_WALK) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_ORIENT;
      end
      ST_ORIENT: state_d = ST_INIT;
      ST_INIT:   state_d = ST_WALK;
      ST_WALK: begin
        // leave once the final group is taken into the output register
        if (cmd_o.emit && sts_i.last_grp) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_orient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ORIENT))
    else $error("accepted word did not start orientation");
  a_init_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |=> (state_q == ST_WALK))
    else $error("init not followed by walk");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.last_grp) |=> (state_q == ST_IDLE))
    else $error("walk continued past the last group");
  a_walk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && !(cmd_o.emit && sts_i.last_grp)) |=> (state_q == ST_WALK))
    else $error("walk ended before the last group");
`endif

endmodule
